// ----- sv/iirlp_pkg.sv -----
// Shared widths, reset values, series constants and MAC control type for the low-pass phasor block.
package iirlp_pkg;

  // Field widths
  localparam int unsigned COEF_W    = 24;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned CH_W      = 4;
  localparam int unsigned PH_W      = 17;
  localparam int unsigned XSUM_W    = 18;
  localparam int unsigned REG_IDX_W = 2;

  // Coefficient reset values, Q2.22
  localparam logic signed [COEF_W-1:0] COEF_A_RST = 24'sd60403;
  localparam logic signed [COEF_W-1:0] COEF_B_RST = -24'sd6849270;
  localparam logic signed [COEF_W-1:0] COEF_C_RST = 24'sd2896582;

  // Quarter-turn Taylor series constants, Q30
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint SIN_DIV [1:6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};
  localparam longint COS_DIV [1:6] = '{64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90, 64'sd132};

  // Control word for one multiply-accumulate request
  typedef struct packed {
    logic en;   // accumulate the product
    logic clr;  // start a new sum with this product
    logic sub;  // subtract instead of add
  } mac_ctl_t;

endpackage

// ----- sv/iirlp_if.sv -----
// Valid/ready stream interfaces for the sample input and the result output.
interface iirlp_in_if;
  import iirlp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         channel;
  logic signed [SMP_W-1:0] sample_value;

  modport source (output valid, channel, sample_value, input ready);
  modport sink (input valid, channel, sample_value, output ready);
endinterface

interface iirlp_out_if;
  import iirlp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         out_channel;
  logic signed [SMP_W-1:0] filtered_value;
  logic                    saturated;
  logic signed [PH_W-1:0]  phasor_real;
  logic signed [PH_W-1:0]  phasor_imag;

  modport source (output valid, out_channel, filtered_value, saturated, phasor_real,
                  phasor_imag, input ready);
  modport sink (input valid, out_channel, filtered_value, saturated, phasor_real,
                phasor_imag, output ready);
endinterface

// ----- sv/iir_lowpass_fourier_phasor.sv -----
// Top level: per-channel biquad low-pass filter followed by a full-cycle DFT phasor.
//
// Usage: one sample request on smp_i (channel, sample_value) gives one result on res_o
// (out_channel, filtered_value, saturated, phasor_real, phasor_imag). Requests whose
// channel is CHANNEL_COUNT or above are taken and dropped without a result.
// Coefficients a, b, c (Q2.22) are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// index 3 is ignored. The user writes them only while the block is idle (not enforced).
// Each request runs through the filter steps (S_RD0, S_RD1, S_FB2, S_FWAIT, S_RND),
// the sweep over the channel's window, one entry per cycle through the single window
// memory read port and the shared two-lane MAC, and the drain and 2/N scaling through
// a reciprocal multiplier (S_DR1 to S_SCL2). A new request is taken only after the
// previous result has been loaded into the output register.
// smp_i.ready is high only while the sequencer waits for a request.
// Reset: coefficients return to their defaults, raw history and per-channel window
// fill counts clear; window entries past the fill count read as zero, so no clearing
// pass runs and the block is ready right after reset.
// Stall: a result waits in the output register until res_o.ready; the next request is
// still taken and its result waits in the last sequencer step until the register frees.
module iir_lowpass_fourier_phasor #(
  parameter int unsigned WINDOW_POINTS = 48,
  parameter int unsigned CHANNEL_COUNT = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [iirlp_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [iirlp_pkg::COEF_W-1:0]         cfg_data_i,
  iirlp_in_if.sink                             smp_i,
  iirlp_out_if.source                          res_o
);
  import iirlp_pkg::*;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2
  } reg_idx_e;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_RD0   = 13'h0002,
    S_RD1   = 13'h0004,
    S_FB2   = 13'h0008,
    S_FWAIT = 13'h0010,
    S_RND   = 13'h0020,
    S_DFT   = 13'h0040,
    S_DR1   = 13'h0080,
    S_DR2   = 13'h0100,
    S_SCL0  = 13'h0200,
    S_SCL1  = 13'h0400,
    S_SCL2  = 13'h0800,
    S_OUT   = 13'h1000
  } state_e;

  // Derived sizes
  localparam int unsigned PW    = $clog2(WINDOW_POINTS);
  localparam int unsigned CW    = $clog2(WINDOW_POINTS + 1);
  localparam int unsigned CHW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned DEPTH = CHANNEL_COUNT * WINDOW_POINTS;
  localparam int unsigned MAW   = $clog2(DEPTH);
  localparam int unsigned LG    = $clog2(WINDOW_POINTS);
  localparam int unsigned ACC_W = (LG + 32 > 44) ? LG + 32 : 44;
  localparam int unsigned VW    = LG + 18;
  localparam int unsigned RW    = VW + 2;
  localparam int unsigned K     = VW + LG;
  localparam int unsigned PRW   = VW + RW;

  localparam longint NPTS = longint'(WINDOW_POINTS);
  localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'(WINDOW_POINTS) - 64'd1)
                                    / 64'(WINDOW_POINTS);
  localparam logic [RW-1:0]             RECIP    = RW'(RECIP64);
  localparam logic [PW-1:0]             LAST_POS = PW'(WINDOW_POINTS - 1);
  localparam logic [CW-1:0]             FULL_CNT = CW'(WINDOW_POINTS);
  localparam logic [MAW-1:0]            NPTS_A   = MAW'(WINDOW_POINTS);
  localparam logic signed [ACC_W-1:0]   RND_HALF = ACC_W'(2097152);
  localparam logic signed [ACC_W-1:0]   Y_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0]   Y_MIN    = ACC_W'(-32768);
  localparam logic signed [ACC_W:0]     HALF_D   = (ACC_W + 1)'(NPTS * 16384);
  localparam logic signed [ACC_W:0]     OFF_V    = (ACC_W + 1)'(NPTS * 131072);

  // Q1.15 sine or cosine of 2*pi*idx/N from a quarter-turn Taylor series
  function automatic logic signed [15:0] trig_q15(input int unsigned idx,
                                                  input logic want_cos);
    longint t, quad, rem, x, smag, cmag, s, c, sq, cq, sv, cv;
    t    = 4 * longint'(idx);
    quad = t / NPTS;
    rem  = t % NPTS;
    x    = (rem * HALF_PI_Q30) / NPTS;
    smag = x;
    cmag = ONE_Q30;
    s    = x;
    c    = ONE_Q30;
    for (int k = 1; k <= 6; k++) begin
      smag = (smag * x) >>> 30;
      smag = ((smag * x) >>> 30) / SIN_DIV[k];
      cmag = (cmag * x) >>> 30;
      cmag = ((cmag * x) >>> 30) / COS_DIV[k];
      if (k % 2 == 1) begin
        s = s - smag;
        c = c - cmag;
      end else begin
        s = s + smag;
        c = c + cmag;
      end
    end
    if (s < 0) s = 0;
    if (c < 0) c = 0;
    sq = (s + 16384) >>> 15;
    cq = (c + 16384) >>> 15;
    if (sq > 32767) sq = 32767;
    if (cq > 32767) cq = 32767;
    case (quad % 4)
      0: begin
        sv = sq;
        cv = cq;
      end
      1: begin
        sv = cq;
        cv = -sq;
      end
      2: begin
        sv = -sq;
        cv = -cq;
      end
      default: begin
        sv = -cq;
        cv = sq;
      end
    endcase
    return want_cos ? 16'(cv) : 16'(sv);
  endfunction

  // Scaled quotient to phasor part, clipped to 17 bits
  function automatic logic signed [PH_W-1:0] ph_clip(input logic [PRW-1:0] p);
    logic [17:0] q;
    logic signed [PH_W-1:0] r;
    q = p[K+17:K];
    if (q < 18'h10000) begin
      r = 17'sh10000;
    end else if (q >= 18'h30000) begin
      r = 17'sh0FFFF;
    end else begin
      r = 17'(q - 18'h20000);
    end
    return r;
  endfunction

  // Sine and cosine tables
  logic signed [SMP_W-1:0] sin_tab [WINDOW_POINTS];
  logic signed [SMP_W-1:0] cos_tab [WINDOW_POINTS];

  for (genvar g = 0; g < WINDOW_POINTS; g++) begin : g_tab
    localparam logic signed [SMP_W-1:0] SinV = trig_q15(g, 1'b0);
    localparam logic signed [SMP_W-1:0] CosV = trig_q15(g, 1'b1);
    assign sin_tab[g] = SinV;
    assign cos_tab[g] = CosV;
  end

  // Registers
  state_e                   state_q, state_d;
  logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;
  logic [CHW-1:0]           ch_q;
  logic signed [XSUM_W-1:0] xs_q;
  logic [MAW-1:0]           base_q;
  logic signed [SMP_W-1:0]  raw0_q [CHANNEL_COUNT];
  logic signed [SMP_W-1:0]  raw1_q [CHANNEL_COUNT];
  logic [PW-1:0]            head_q [CHANNEL_COUNT];
  logic [CW-1:0]            cnt_q  [CHANNEL_COUNT];
  logic [PW-1:0]            rp_q, pos_q, rd_pos_q;
  logic                     rd_vld_q;
  logic signed [SMP_W-1:0]  rdata_q;
  logic signed [SMP_W-1:0]  y_q;
  logic                     sat_q;
  logic [VW-1:0]            v_re_q, v_im_q;
  logic [PRW-1:0]           sc_prod_q;
  logic signed [PH_W-1:0]   ph_re_q;
  logic                     out_vld_q;
  logic [CH_W-1:0]          out_ch_q;
  logic signed [SMP_W-1:0]  out_y_q;
  logic                     out_sat_q;
  logic signed [PH_W-1:0]   out_re_q, out_im_q;

  // Combinational signals
  logic                     in_ok, take, out_load;
  logic [CHW-1:0]           ch_in;
  logic [PW-1:0]            head_cur, head_new, head_nxt, rp_nxt;
  logic [CW-1:0]            cnt_cur, cnt_new;
  logic [MAW-1:0]           mem_raddr, mem_waddr;
  logic signed [SMP_W-1:0]  win_val;
  logic signed [ACC_W-1:0]  acc_re, acc_im, rnd_sum, y_full;
  logic signed [SMP_W-1:0]  y_d;
  logic                     sat_d;
  logic signed [ACC_W:0]    t_re, t_im, v_re_full, v_im_full;
  mac_ctl_t                 mac_ctl;
  logic signed [COEF_W-1:0] op_a;
  logic signed [XSUM_W-1:0] op_b;
  logic signed [SMP_W-1:0]  op_c, op_d;

  // Input handshake
  assign in_ok       = {1'b0, smp_i.channel} < (CH_W + 1)'(CHANNEL_COUNT);
  assign ch_in       = CHW'(smp_i.channel);
  assign smp_i.ready = (state_q == S_IDLE);
  assign take        = smp_i.valid && smp_i.ready && in_ok;

  // Coefficient writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= COEF_A_RST;
      coef_b_q <= COEF_B_RST;
      coef_c_q <= COEF_C_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_A: coef_a_q <= cfg_data_i;
        REG_COEF_B: coef_b_q <= cfg_data_i;
        REG_COEF_C: coef_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window pointer arithmetic for the current channel
  assign head_cur = head_q[ch_q];
  assign cnt_cur  = cnt_q[ch_q];
  assign head_new = (head_cur == '0) ? LAST_POS : head_cur - PW'(1);
  assign head_nxt = (head_cur == LAST_POS) ? '0 : head_cur + PW'(1);
  assign rp_nxt   = (rp_q == LAST_POS) ? '0 : rp_q + PW'(1);
  assign cnt_new  = (cnt_cur == FULL_CNT) ? cnt_cur : cnt_cur + CW'(1);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (take) state_d = S_RD0;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = S_FB2;
      S_FB2:   state_d = S_FWAIT;
      S_FWAIT: state_d = S_RND;
      S_RND:   state_d = S_DFT;
      S_DFT:   if (pos_q == LAST_POS) state_d = S_DR1;
      S_DR1:   state_d = S_DR2;
      S_DR2:   state_d = S_SCL0;
      S_SCL0:  state_d = S_SCL1;
      S_SCL1:  state_d = S_SCL2;
      S_SCL2:  state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the request and advance the raw history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        raw0_q[i] <= '0;
        raw1_q[i] <= '0;
      end
    end else if (take) begin
      raw0_q[ch_in] <= smp_i.sample_value;
      raw1_q[ch_in] <= raw0_q[ch_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ch_q   <= ch_in;
      xs_q   <= XSUM_W'(smp_i.sample_value) + (XSUM_W'(raw0_q[ch_in]) <<< 1)
              + XSUM_W'(raw1_q[ch_in]);
      base_q <= MAW'(ch_in) * NPTS_A;
    end
  end

  // Per-channel head and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (state_q == S_RND) begin
      head_q[ch_q] <= head_new;
      cnt_q[ch_q]  <= cnt_new;
    end
  end

  // Window sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_DFT);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= pos_q;
    if (state_q == S_RND) begin
      rp_q  <= head_new;
      pos_q <= '0;
    end else if (state_q == S_DFT) begin
      rp_q  <= rp_nxt;
      pos_q <= pos_q + PW'(1);
    end
  end

  // Window memory: write the new output, read one entry a cycle
  logic signed [SMP_W-1:0] win_mem [DEPTH];

  always_comb begin
    case (state_q)
      S_RD0:   mem_raddr = base_q + MAW'(head_cur);
      S_RD1:   mem_raddr = base_q + MAW'(head_nxt);
      default: mem_raddr = base_q + MAW'(rp_q);
    endcase
  end

  assign mem_waddr = base_q + MAW'(head_new);

  always_ff @(posedge clk_i) begin
    if (state_q == S_RND) begin
      win_mem[mem_waddr] <= y_d;
    end
    rdata_q <= win_mem[mem_raddr];
  end

  // Entries past the fill count read as zero
  always_comb begin
    case (state_q)
      S_RD1:   win_val = (cnt_cur != '0) ? rdata_q : '0;
      S_FB2:   win_val = (cnt_cur > CW'(1)) ? rdata_q : '0;
      default: win_val = (CW'(rd_pos_q) < cnt_cur) ? rdata_q : '0;
    endcase
  end

  // Operand selection for the shared MAC
  always_comb begin
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    op_c    = '0;
    op_d    = '0;
    case (state_q)
      S_RD0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        op_a    = coef_a_q;
        op_b    = xs_q;
      end
      S_RD1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        op_a    = coef_b_q;
        op_b    = XSUM_W'(win_val);
      end
      S_FB2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        op_a    = coef_c_q;
        op_b    = XSUM_W'(win_val);
      end
      default: begin
        if (rd_vld_q) begin
          mac_ctl = '{en: 1'b1, clr: (rd_pos_q == '0), sub: 1'b0};
          op_a    = COEF_W'(sin_tab[rd_pos_q]);
          op_b    = XSUM_W'(win_val);
          op_c    = cos_tab[rd_pos_q];
          op_d    = win_val;
        end
      end
    endcase
  end

  iirlp_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .op_c_i  (op_c),
    .op_d_i  (op_d),
    .acc_a_o (acc_re),
    .acc_b_o (acc_im)
  );

  // Round half up and saturate the filter output
  assign rnd_sum = acc_re + RND_HALF;
  assign y_full  = rnd_sum >>> 22;

  always_comb begin
    sat_d = 1'b1;
    if (y_full > Y_MAX) begin
      y_d = 16'sh7FFF;
    end else if (y_full < Y_MIN) begin
      y_d = 16'sh8000;
    end else begin
      y_d   = y_full[SMP_W-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RND) begin
      y_q   <= y_d;
      sat_q <= sat_d;
    end
  end

  // Scale by 2/N: drop the 2^15 factor with rounding, offset positive, divide by N
  assign t_re      = $signed({acc_re, 1'b0}) + HALF_D;
  assign t_im      = $signed({acc_im, 1'b0}) + HALF_D;
  assign v_re_full = (t_re >>> 15) + OFF_V;
  assign v_im_full = (t_im >>> 15) + OFF_V;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_SCL0: begin
        v_re_q <= v_re_full[VW-1:0];
        v_im_q <= v_im_full[VW-1:0];
      end
      S_SCL1: sc_prod_q <= PRW'(v_re_q) * PRW'(RECIP);
      S_SCL2: begin
        ph_re_q   <= ph_clip(sc_prod_q);
        sc_prod_q <= PRW'(v_im_q) * PRW'(RECIP);
      end
      default: ;
    endcase
  end

  // Output register: load when empty or being drained
  assign out_load = (state_q == S_OUT) && (!out_vld_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q  <= CH_W'(ch_q);
      out_y_q   <= y_q;
      out_sat_q <= sat_q;
      out_re_q  <= ph_re_q;
      out_im_q  <= ph_clip(sc_prod_q);
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.out_channel    = out_ch_q;
  assign res_o.filtered_value = out_y_q;
  assign res_o.saturated      = out_sat_q;
  assign res_o.phasor_real    = out_re_q;
  assign res_o.phasor_imag    = out_im_q;

  // Checks
  a_sweep_starts_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DFT) && (pos_q == '0) |-> rp_q == head_q[ch_q])
    else $error("window sweep does not start at the newest entry");

  a_fill_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RND) |=> cnt_q[ch_q] != '0)
    else $error("fill count empty after a push");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || res_o.ready))
    else $error("result register overwritten while held");

endmodule

// ----- sv/iirlp_mac.sv -----
// Shared two-lane multiply-accumulate unit with a registered product stage.
module iirlp_mac #(
  parameter int unsigned ACC_W = 44
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  iirlp_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [iirlp_pkg::COEF_W-1:0]   op_a_i,
  input  logic signed [iirlp_pkg::XSUM_W-1:0]   op_b_i,
  input  logic signed [iirlp_pkg::SMP_W-1:0]    op_c_i,
  input  logic signed [iirlp_pkg::SMP_W-1:0]    op_d_i,
  output logic signed [ACC_W-1:0]               acc_a_o,
  output logic signed [ACC_W-1:0]               acc_b_o
);
  import iirlp_pkg::*;

  localparam int unsigned PA_W = COEF_W + XSUM_W;
  localparam int unsigned PB_W = 2 * SMP_W;

  logic signed [PA_W-1:0]  prod_a_d, prod_a_q;
  logic signed [PB_W-1:0]  prod_b_d, prod_b_q;
  mac_ctl_t                ctl_q;
  logic signed [ACC_W-1:0] ext_a, ext_b;
  logic signed [ACC_W-1:0] acc_a_q, acc_b_q;

  // Multiply, one product per lane
  assign prod_a_d = op_a_i * op_b_i;
  assign prod_b_d = op_c_i * op_d_i;

  // Hold the control word alongside the products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
  end

  // Accumulate the registered products
  assign ext_a = ACC_W'(prod_a_q);
  assign ext_b = ACC_W'(prod_b_q);

  always_ff @(posedge clk_i) begin
    if (ctl_q.en) begin
      acc_a_q <= (ctl_q.clr ? '0 : acc_a_q) + (ctl_q.sub ? -ext_a : ext_a);
      acc_b_q <= (ctl_q.clr ? '0 : acc_b_q) + (ctl_q.sub ? -ext_b : ext_b);
    end
  end

  assign acc_a_o = acc_a_q;
  assign acc_b_o = acc_b_q;

endmodule

// ----- tb/iir_lowpass_fourier_phasor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the twelve-channel low-pass filter and full-cycle phasor block.
module iir_lowpass_fourier_phasor_tb;
  import iirlp_pkg::*;

  localparam int unsigned WINDOW_POINTS = 48;
  localparam int unsigned CHANNEL_COUNT = 12;
  localparam int unsigned LATENCY       = WINDOW_POINTS + 12;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam longint      PHASOR_DIV    = longint'(WINDOW_POINTS) * 32768;

  // Coefficient register indexes
  localparam logic [REG_IDX_W-1:0] REG_COEF_A = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_C = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;

  typedef struct {
    logic [CH_W-1:0]         channel;
    logic signed [SMP_W-1:0] filtered;
    logic                    saturated;
    logic signed [PH_W-1:0]  re;
    logic signed [PH_W-1:0]  im;
  } phasor_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0]    cfg_data;

  iirlp_in_if  smp_if ();
  iirlp_out_if res_if ();

  iir_lowpass_fourier_phasor #(
    .WINDOW_POINTS(WINDOW_POINTS),
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .smp_i     (smp_if),
    .res_o     (res_if)
  );

  // Filter and phasor state of the predictor
  logic signed [COEF_W-1:0] model_a;
  logic signed [COEF_W-1:0] model_b;
  logic signed [COEF_W-1:0] model_c;
  logic signed [SMP_W-1:0]  raw_hist [CHANNEL_COUNT][2];
  logic signed [SMP_W-1:0]  filt_win [CHANNEL_COUNT][WINDOW_POINTS];
  int                       twiddle_sin [WINDOW_POINTS];
  int                       twiddle_cos [WINDOW_POINTS];
  phasor_result_t           expected_phasors [$];

  // Waveform state of the stimulus, one tone per channel
  int unsigned     wave_pos  [CHANNEL_COUNT];
  int unsigned     wave_step [CHANNEL_COUNT];
  int              wave_amp  [CHANNEL_COUNT];
  int              wave_dc   [CHANNEL_COUNT];
  logic [CH_W-1:0] focus_ch;

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          calm;

  // Run the clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Build the Q1.15 sin/cos tables from a quarter-turn Taylor series in Q30
  function automatic void build_twiddles();
    longint n, t, quad, rem, x, smag, cmag, s, c, sq, cq;
    n = WINDOW_POINTS;
    for (int i = 0; i < WINDOW_POINTS; i++) begin
      t    = 4 * i;
      quad = t / n;
      rem  = t % n;
      x    = (rem * HALF_PI_Q30) / n;
      smag = x;
      cmag = ONE_Q30;
      s    = x;
      c    = ONE_Q30;
      for (int k = 1; k <= 6; k++) begin
        smag = (smag * x) >>> 30;
        smag = ((smag * x) >>> 30) / ((2 * k) * (2 * k + 1));
        cmag = (cmag * x) >>> 30;
        cmag = ((cmag * x) >>> 30) / ((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          s -= smag;
          c -= cmag;
        end else begin
          s += smag;
          c += cmag;
        end
      end
      if (s < 0) s = 0;
      if (c < 0) c = 0;
      sq = (s + 16384) >>> 15;
      cq = (c + 16384) >>> 15;
      if (sq > 32767) sq = 32767;
      if (cq > 32767) cq = 32767;
      case (quad & 3)
        0: begin
          twiddle_sin[i] = int'(sq);
          twiddle_cos[i] = int'(cq);
        end
        1: begin
          twiddle_sin[i] = int'(cq);
          twiddle_cos[i] = -int'(sq);
        end
        2: begin
          twiddle_sin[i] = -int'(sq);
          twiddle_cos[i] = -int'(cq);
        end
        default: begin
          twiddle_sin[i] = -int'(cq);
          twiddle_cos[i] = int'(sq);
        end
      endcase
    end
  endfunction

  // Scale a DFT sum by 2/N with round-half-up floor division, then clip
  function automatic longint scale_phasor(input longint sum);
    longint num, q;
    num = 2 * sum + PHASOR_DIV / 2;
    q   = num / PHASOR_DIV;
    if ((num % PHASOR_DIV) != 0 && num < 0) q -= 1;
    if (q > 65535) q = 65535;
    else if (q < -65536) q = -65536;
    return q;
  endfunction

  // Advance one channel's filter and window; return 0 for a dropped channel
  function automatic bit predict_phasor(input logic [CH_W-1:0] ch,
                                        input logic signed [SMP_W-1:0] x0,
                                        output phasor_result_t res);
    longint acc, y, sum_s, sum_c;
    logic   sat;
    res = '{default: '0};
    if (ch >= CHANNEL_COUNT) return 1'b0;
    acc = longint'(model_a) * longint'(x0)
        + 2 * longint'(model_a) * longint'(raw_hist[ch][0])
        + longint'(model_a) * longint'(raw_hist[ch][1])
        - longint'(model_b) * longint'(filt_win[ch][0])
        - longint'(model_c) * longint'(filt_win[ch][1]);
    y   = (acc + 64'sd2097152) >>> 22;
    sat = 1'b0;
    if (y > 32767) begin
      y   = 32767;
      sat = 1'b1;
    end else if (y < -32768) begin
      y   = -32768;
      sat = 1'b1;
    end
    raw_hist[ch][1] = raw_hist[ch][0];
    raw_hist[ch][0] = x0;
    for (int i = WINDOW_POINTS - 1; i > 0; i--) filt_win[ch][i] = filt_win[ch][i-1];
    filt_win[ch][0] = y[SMP_W-1:0];
    sum_s = 0;
    sum_c = 0;
    for (int i = 0; i < WINDOW_POINTS; i++) begin
      sum_s += longint'(filt_win[ch][i]) * twiddle_sin[i];
      sum_c += longint'(filt_win[ch][i]) * twiddle_cos[i];
    end
    res.channel   = ch;
    res.filtered  = y[SMP_W-1:0];
    res.saturated = sat;
    res.re        = PH_W'(scale_phasor(sum_s));
    res.im        = PH_W'(scale_phasor(sum_c));
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Send one sample request, predict its result, then maybe idle
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] val);
    phasor_result_t res;
    smp_if.valid        <= 1'b1;
    smp_if.channel      <= ch;
    smp_if.sample_value <= val;
    do @(posedge clk_i); while (smp_if.ready !== 1'b1);
    if (predict_phasor(ch, val, res)) expected_phasors.push_back(res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Write one coefficient register and mirror it in the predictor
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEF_A: model_a = data;
      REG_COEF_B: model_b = data;
      REG_COEF_C: model_c = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Hold off new requests until every result is back and the block has gone quiet
  task automatic drain_results();
    smp_if.valid <= 1'b0;
    while (expected_phasors.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // Next sample for a channel: mostly a noisy tone, sometimes raw or extreme values
  function automatic logic signed [SMP_W-1:0] next_sample(input logic [CH_W-1:0] ch);
    int unsigned pick;
    int          v;
    pick = $urandom_range(0, 99);
    if (ch >= CHANNEL_COUNT || pick < 15) return SMP_W'($urandom);
    if (pick < 25) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        2:       return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    v = (wave_amp[ch] * twiddle_sin[wave_pos[ch]]) >>> 15;
    v += wave_dc[ch] + int'($urandom_range(0, 255)) - 128;
    wave_pos[ch] = (wave_pos[ch] + wave_step[ch]) % WINDOW_POINTS;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[SMP_W-1:0];
  endfunction

  // Send a number of accepted-channel requests, with dropped channels mixed in
  task automatic run_random(input int unsigned count);
    logic [CH_W-1:0] ch;
    int unsigned     pick;
    int unsigned     sent;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      wave_amp[c]  = int'($urandom_range(0, 40000));
      wave_dc[c]   = int'($urandom_range(0, 8000)) - 4000;
      wave_step[c] = ($urandom_range(0, 3) == 0) ? 2 : 1;
      wave_pos[c]  = $urandom_range(0, WINDOW_POINTS - 1);
    end
    sent = 0;
    while (sent < count) begin
      if (sent % 100 == 0) focus_ch = CH_W'($urandom_range(0, CHANNEL_COUNT - 1));
      pick = $urandom_range(0, 99);
      if (pick < 8) ch = CH_W'($urandom_range(CHANNEL_COUNT, (1 << CH_W) - 1));
      else if (pick < 55) ch = focus_ch;
      else ch = CH_W'($urandom_range(0, CHANNEL_COUNT - 1));
      send_sample(ch, next_sample(ch));
      if (ch < CHANNEL_COUNT) sent++;
    end
  endtask

  // Extremes and dropped channels at the reset coefficients
  task automatic test_reset_coefficients();
    send_sample(4'd0, 16'sh7FFF);
    send_sample(4'd0, 16'sh7FFF);
    send_sample(4'd0, 16'sh8000);
    send_sample(4'd0, 16'sh0000);
    send_sample(4'd11, 16'sh8000);
    send_sample(4'd11, 16'sh7FFF);
    send_sample(4'd12, 16'sh1234);
    send_sample(4'd15, 16'shFFFF);
    send_sample(4'd5, 16'shFFFF);
    send_sample(4'd5, 16'sh5555);
    run_random(300);
  endtask

  // Coefficient extremes drive the filter into clipping both ways
  task automatic test_saturation();
    drain_results();
    write_reg(REG_COEF_A, COEF_MAX);
    write_reg(REG_COEF_B, COEF_MIN);
    write_reg(REG_COEF_C, COEF_MIN);
    repeat (3) send_sample(4'd1, 16'sh7FFF);
    repeat (3) send_sample(4'd1, 16'sh8000);
    run_random(200);
    drain_results();
    // The spare register index must leave the coefficients alone
    write_reg(REG_UNUSED, COEF_W'($urandom));
    write_reg(REG_COEF_A, COEF_MIN);
    write_reg(REG_COEF_B, COEF_MAX);
    write_reg(REG_COEF_C, COEF_MAX);
    repeat (2) send_sample(4'd2, 16'sh7FFF);
    repeat (2) send_sample(4'd2, 16'sh8000);
    run_random(200);
  endtask

  // Pure feed-forward quarter/half/quarter average passes the tones through
  task automatic test_moving_average();
    drain_results();
    write_reg(REG_COEF_A, 24'sd1048576);
    write_reg(REG_COEF_B, '0);
    write_reg(REG_COEF_C, '0);
    run_random(300);
  endtask

  // All-zero coefficients flush the windows to zero
  task automatic test_zero_coefficients();
    drain_results();
    write_reg(REG_COEF_A, '0);
    run_random(100);
  endtask

  task automatic test_random_coefficients();
    repeat (2) begin
      drain_results();
      write_reg(REG_COEF_A, COEF_W'($urandom));
      write_reg(REG_COEF_B, COEF_W'($urandom));
      write_reg(REG_COEF_C, COEF_W'($urandom));
      run_random(200);
    end
  endtask

  // Back-to-back requests and an always-ready receiver at the reset coefficients
  task automatic test_back_to_back();
    drain_results();
    calm = 1'b1;
    write_reg(REG_COEF_A, COEF_A_RST);
    write_reg(REG_COEF_B, COEF_B_RST);
    write_reg(REG_COEF_C, COEF_C_RST);
    run_random(300);
    drain_results();
  endtask

  initial begin : main
    smp_if.valid        <= 1'b0;
    smp_if.channel      <= '0;
    smp_if.sample_value <= '0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    rst_ni              <= 1'b0;
    calm           = 1'b0;
    mismatch_count = 0;
    focus_ch       = '0;
    model_a        = COEF_A_RST;
    model_b        = COEF_B_RST;
    model_c        = COEF_C_RST;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      raw_hist[c][0] = '0;
      raw_hist[c][1] = '0;
      for (int i = 0; i < WINDOW_POINTS; i++) filt_win[c][i] = '0;
    end
    build_twiddles();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_coefficients();
    test_saturation();
    test_moving_average();
    test_zero_coefficients();
    test_random_coefficients();
    test_back_to_back();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stall the receiver in bursts between ready stretches
  initial begin : drive_ready
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 150)) @(posedge clk_i);
      if (!calm) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    phasor_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_phasors.size() == 0) begin
        report_mismatch($sformatf("result on channel %0d with nothing pending",
                                  res_if.out_channel));
      end else begin
        want = expected_phasors.pop_front();
        if (res_if.out_channel !== want.channel)
          report_mismatch($sformatf("out_channel %0d, expected %0d",
                                    res_if.out_channel, want.channel));
        if (res_if.filtered_value !== want.filtered)
          report_mismatch($sformatf("ch %0d filtered_value %0d, expected %0d",
                                    want.channel, res_if.filtered_value, want.filtered));
        if (res_if.saturated !== want.saturated)
          report_mismatch($sformatf("ch %0d saturated %b, expected %b",
                                    want.channel, res_if.saturated, want.saturated));
        if (res_if.phasor_real !== want.re)
          report_mismatch($sformatf("ch %0d phasor_real %0d, expected %0d",
                                    want.channel, res_if.phasor_real, want.re));
        if (res_if.phasor_imag !== want.im)
          report_mismatch($sformatf("ch %0d phasor_imag %0d, expected %0d",
                                    want.channel, res_if.phasor_imag, want.im));
      end
    end
  end

  // End the run when no request moves on either side for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
